### hdl/stepper_position_sequencer_macros.svh
// assertion helpers for the stepper sequencer
`ifndef STEPPER_POSITION_SEQUENCER_MACROS_SVH
`define STEPPER_POSITION_SEQUENCER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/stp_pkg.sv
`timescale 1ns / 1ps
package stp_pkg;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_STOP = 2'd2;

  localparam logic [1:0] CFG_TRAVEL_STEPS = 2'd0;
  localparam logic [1:0] CFG_STEP_PERIOD  = 2'd1;
  localparam logic [1:0] CFG_HALF_STEP    = 2'd2;

  localparam logic [6:0] POS_MAX = 7'd100;

  // floor(x / 100) == (x * RECIP_K) >> RECIP_SHIFT for every x below 2^23
  localparam int          RECIP_SHIFT = 30;
  localparam logic [23:0] RECIP_K     = 24'd10737419;
  localparam int          SCALE_W     = 40;
  localparam int          PROD_W      = SCALE_W + 7;

  localparam logic [15:0]        TRAVEL_STEPS_RESET = 16'd4096;
  localparam logic [15:0]        STEP_PERIOD_RESET  = 16'd1000;
  localparam logic [SCALE_W-1:0] SCALE_RESET        = 40'(64'd4096 * 64'd10737419);

  typedef struct packed {
    logic [SCALE_W-1:0] steps_scale;  // travel steps * RECIP_K
    logic [15:0]        step_period;
    logic               half_step;
  } cfg_t;

  typedef struct packed {
    logic       ignored;
    logic       done_res;
    logic       busy_res;
    logic [6:0] position;
    logic [3:0] phases;
  } res_t;

  function automatic logic [3:0] half_pattern(input logic [2:0] idx);
    logic [3:0] p;
    case (idx)
      3'd0:    p = 4'b1001;
      3'd1:    p = 4'b0001;
      3'd2:    p = 4'b0011;
      3'd3:    p = 4'b0010;
      3'd4:    p = 4'b0110;
      3'd5:    p = 4'b0100;
      3'd6:    p = 4'b1100;
      default: p = 4'b1000;
    endcase
    return p;
  endfunction

  function automatic logic [3:0] full_pattern(input logic [1:0] idx);
    logic [3:0] p;
    case (idx)
      2'd0:    p = 4'b1001;
      2'd1:    p = 4'b0011;
      2'd2:    p = 4'b0110;
      default: p = 4'b1100;
    endcase
    return p;
  endfunction

endpackage

### hdl/stp_cfg.sv
`timescale 1ns / 1ps
module stp_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output stp_pkg::cfg_t cfg
);
  import stp_pkg::*;

  logic [SCALE_W-1:0] scale_r;
  logic [15:0]        period_r;
  logic               half_r;
  logic               wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_RESET;
      period_r <= STEP_PERIOD_RESET;
      half_r   <= 1'b1;
    end else if (wr) begin
      case (cfg_index)
        CFG_TRAVEL_STEPS: begin
          // keep only the scaled form, the step count path needs nothing else
          scale_r <= {24'd0, cfg_data} * {16'd0, RECIP_K};
        end
        CFG_STEP_PERIOD: period_r <= cfg_data;
        CFG_HALF_STEP:   half_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.steps_scale = scale_r;
  assign cfg.step_period = period_r;
  assign cfg.half_step   = half_r;

endmodule

### hdl/stp_core.sv
`timescale 1ns / 1ps
module stp_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [1:0]    op,
  input  logic [7:0]    target,
  input  stp_pkg::cfg_t cfg,
  output stp_pkg::res_t res
);
  import stp_pkg::*;

  logic [6:0]  cur_pos_r, cur_pos_nxt;
  logic [6:0]  goal_r, goal_nxt;
  logic [15:0] steps_r, steps_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [16:0] tick_r, tick_nxt;
  logic        moving_r, moving_nxt;
  logic        fwd_r, fwd_nxt;
  logic [3:0]  coil_r, coil_nxt;

  logic [6:0]        tgt;
  logic [6:0]        diff;
  logic [PROD_W-1:0] prod;
  logic [16:0]       n_raw;
  logic [15:0]       n_steps;
  logic [16:0]       period;
  logic [16:0]       tick_inc;
  logic [2:0]        idx_step;
  logic [15:0]       steps_dec;
  logic              done;
  logic              dropped;

  assign tgt  = (target > {1'b0, POS_MAX}) ? POS_MAX : target[6:0];
  assign diff = (cur_pos_r > tgt) ? (cur_pos_r - tgt) : (tgt - cur_pos_r);

  // beat count = diff * travel steps / 100 through the prescaled reciprocal
  assign prod    = {40'd0, diff} * {7'd0, cfg.steps_scale};
  assign n_raw   = prod[PROD_W-1:RECIP_SHIFT];
  assign n_steps = (n_raw == 17'd0) ? 16'd1 : n_raw[15:0];

  always_comb begin
    period = cfg.half_step ? {1'b0, cfg.step_period} : {cfg.step_period, 1'b0};
    if (period == 17'd0) period = 17'd1;
  end

  assign tick_inc  = tick_r + 17'd1;
  assign steps_dec = steps_r - 16'd1;

  always_comb begin
    idx_step = fwd_r ? (idx_r + 3'd1) : (idx_r - 3'd1);
    if (!cfg.half_step) idx_step = {1'b0, idx_step[1:0]};
  end

  always_comb begin
    cur_pos_nxt = cur_pos_r;
    goal_nxt    = goal_r;
    steps_nxt   = steps_r;
    idx_nxt     = idx_r;
    tick_nxt    = tick_r;
    moving_nxt  = moving_r;
    fwd_nxt     = fwd_r;
    coil_nxt    = coil_r;
    done        = 1'b0;
    dropped     = 1'b0;
    case (op)
      OP_SET: begin
        if (moving_r) begin
          dropped = 1'b1;
        end else if (tgt != cur_pos_r) begin
          fwd_nxt    = cur_pos_r > tgt;
          steps_nxt  = n_steps;
          goal_nxt   = tgt;
          idx_nxt    = 3'd0;
          tick_nxt   = 17'd0;
          moving_nxt = 1'b1;
          coil_nxt   = cfg.half_step ? half_pattern(3'd0) : full_pattern(2'd0);
        end
      end
      OP_TICK: begin
        if (moving_r) begin
          tick_nxt = tick_inc;
          if (tick_inc >= period) begin
            tick_nxt  = 17'd0;
            steps_nxt = steps_dec;
            idx_nxt   = idx_step;
            if (steps_dec == 16'd0) begin
              coil_nxt    = 4'd0;
              cur_pos_nxt = goal_r;
              moving_nxt  = 1'b0;
              done        = 1'b1;
            end else begin
              coil_nxt = cfg.half_step ? half_pattern(idx_step) : full_pattern(idx_step[1:0]);
            end
          end
        end
      end
      OP_STOP: begin
        coil_nxt   = 4'd0;
        moving_nxt = 1'b0;
        steps_nxt  = 16'd0;
        tick_nxt   = 17'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_pos_r <= 7'd0;
      goal_r    <= 7'd0;
      steps_r   <= 16'd0;
      idx_r     <= 3'd0;
      tick_r    <= 17'd0;
      moving_r  <= 1'b0;
      fwd_r     <= 1'b0;
      coil_r    <= 4'd0;
    end else if (en) begin
      cur_pos_r <= cur_pos_nxt;
      goal_r    <= goal_nxt;
      steps_r   <= steps_nxt;
      idx_r     <= idx_nxt;
      tick_r    <= tick_nxt;
      moving_r  <= moving_nxt;
      fwd_r     <= fwd_nxt;
      coil_r    <= coil_nxt;
    end
  end

  assign res.phases   = coil_nxt;
  assign res.position = cur_pos_nxt;
  assign res.busy_res = moving_nxt;
  assign res.done_res = done;
  assign res.ignored  = dropped;

endmodule

### hdl/stepper_position_sequencer.sv
`timescale 1ns / 1ps
// Half-step / full-step driver for a four-phase unipolar stepper with percent
// position tracking.
// in_*  : one word per command; in_tuser carries the op (tick, set target,
//         stop), in_tdata carries the target percent.
// out_* : exactly one word per accepted command, giving the coil drive, the
//         tracked position and the busy / done / ignored flags.
// cfg_* : register writes (0 total steps, 1 step period, 2 half-step mode);
//         cfg_ready is always high, a total steps write is usable next cycle.
// From input accept to output valid a word passes an input register, then the
// state update and beat count (one 7 x 40 multiply) feeding the output
// register. One word is accepted every cycle while the output drains.
// When the receiver stalls, the output register holds its word and the input
// register holds one more; in_tready drops only while both are full.
// Synchronous reset clears both registers, turns the coils off, sets the
// position to 0 and loads the register defaults (4096, 1000, half-step).
`include "stepper_position_sequencer_macros.svh"
module stepper_position_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] target
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] phases, [10:4] position, [11] busy_res,
                                  // [12] done_res, [13] ignored, [15:14] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import stp_pkg::*;

  logic       s1_valid_r;
  logic [1:0] s1_op_r;
  logic [7:0] s1_target_r;
  logic       out_valid_r;
  res_t       out_res_r;
  logic       s2_free;
  logic       adv;
  cfg_t       cfg;
  res_t       res;

  assign s2_free   = !out_valid_r || out_tready;
  assign adv       = s1_valid_r && s2_free;
  assign in_tready = !s1_valid_r || s2_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r     <= in_tuser;
      s1_target_r <= in_tdata;
    end
  end

  stp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  stp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .op     (s1_op_r),
    .target (s1_target_r),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r};

  `SPS_ASSERT_NOW(a_ready_only_on_stall, !in_tready, out_tvalid && !out_tready,
                  "input stalled without an output stall")
  `SPS_ASSERT_NEXT(a_item_reaches_output, adv, out_tvalid,
                   "advanced word did not reach the output")
  `SPS_ASSERT_NOW(a_idle_coils_off, out_tvalid && !out_tdata[11], out_tdata[3:0] == 4'd0,
                  "coils driven while idle")
  `SPS_ASSERT_NOW(a_drop_only_busy, out_tvalid && out_tdata[13], out_tdata[11],
                  "target dropped while not busy")

endmodule

### test/stepper_status_checker.sv
`timescale 1ns / 1ps
module stepper_status_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] target
  input  logic [1:0]  in_tuser,   // [1:0] op
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [3:0] phases, [10:4] position, [11] busy_res,
                                  // [12] done_res, [13] ignored, [15:14] zero
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fault_count,
  output int          status_backlog
);
  import stp_pkg::*;

  // register copies
  logic [15:0] cfg_total;
  logic [15:0] cfg_period;
  logic        cfg_half;

  // motor state
  logic [6:0]  pos_now;
  logic [6:0]  pos_goal;
  logic [15:0] beats_left;
  logic [2:0]  beat_idx;
  logic [16:0] tick_cnt;
  logic        running;
  logic        advancing;
  logic [3:0]  coils;

  res_t pending_status[$];
  res_t got;
  res_t want;
  res_t next_status;
  int   faults;

  function automatic logic [3:0] coil_pattern(input logic [2:0] idx, input logic half);
    logic [3:0] p;
    if (half) begin
      case (idx)
        3'd0:    p = 4'b1001;
        3'd1:    p = 4'b0001;
        3'd2:    p = 4'b0011;
        3'd3:    p = 4'b0010;
        3'd4:    p = 4'b0110;
        3'd5:    p = 4'b0100;
        3'd6:    p = 4'b1100;
        default: p = 4'b1000;
      endcase
    end else begin
      case (idx[1:0])
        2'd0:    p = 4'b1001;
        2'd1:    p = 4'b0011;
        2'd2:    p = 4'b0110;
        default: p = 4'b1100;
      endcase
    end
    return p;
  endfunction

  task automatic clear_motor();
    cfg_total  = TRAVEL_STEPS_RESET;
    cfg_period = STEP_PERIOD_RESET;
    cfg_half   = 1'b1;
    pos_now    = '0;
    pos_goal   = '0;
    beats_left = '0;
    beat_idx   = '0;
    tick_cnt   = '0;
    running    = 1'b0;
    advancing  = 1'b0;
    coils      = '0;
  endtask

  task automatic step_motor_model(input logic [1:0] op, input logic [7:0] tgt,
                                  output res_t status);
    logic [6:0]  goal;
    logic [6:0]  span;
    logic [22:0] beats;
    logic [16:0] per;
    logic        fin;
    logic        drop;
    fin  = 1'b0;
    drop = 1'b0;
    case (op)
      OP_SET: begin
        if (running) begin
          drop = 1'b1;
        end else begin
          goal = (tgt > 8'd100) ? POS_MAX : tgt[6:0];
          if (goal != pos_now) begin
            advancing = pos_now > goal;
            span = advancing ? pos_now - goal : goal - pos_now;
            beats = 23'(span) * 23'(cfg_total) / 23'd100;
            if (beats == '0) beats = 23'd1;
            beats_left = beats[15:0];
            pos_goal   = goal;
            beat_idx   = '0;
            tick_cnt   = '0;
            running    = 1'b1;
            coils      = coil_pattern(3'd0, cfg_half);
          end
        end
      end
      OP_TICK: begin
        if (running) begin
          tick_cnt = tick_cnt + 17'd1;
          // full-step beats last twice as long, zero acts as one
          per = cfg_half ? {1'b0, cfg_period} : {cfg_period, 1'b0};
          if (per == '0) per = 17'd1;
          if (tick_cnt >= per) begin
            tick_cnt   = '0;
            beats_left = beats_left - 16'd1;
            beat_idx   = advancing ? beat_idx + 3'd1 : beat_idx - 3'd1;
            if (!cfg_half) beat_idx[2] = 1'b0;
            if (beats_left == '0) begin
              coils   = '0;
              pos_now = pos_goal;
              running = 1'b0;
              fin     = 1'b1;
            end else begin
              coils = coil_pattern(beat_idx, cfg_half);
            end
          end
        end
      end
      OP_STOP: begin
        coils      = '0;
        running    = 1'b0;
        beats_left = '0;
        tick_cnt   = '0;
      end
      default: ;
    endcase
    status.phases   = coils;
    status.position = pos_now;
    status.busy_res = running;
    status.done_res = fin;
    status.ignored  = drop;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_motor();
      pending_status.delete();
      fault_count    <= 0;
      status_backlog <= 0;
    end else begin
      faults = fault_count;
      if (out_tvalid && out_tready) begin
        got = out_tdata[13:0];
        if (pending_status.size() == 0) begin
          faults = faults + 1;
          if (faults <= 10)
            $display("unexpected status word %h", out_tdata);
        end else begin
          want = pending_status.pop_front();
          if (got.phases !== want.phases || got.position !== want.position ||
              got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
              got.ignored !== want.ignored || out_tdata[15:14] !== 2'b00) begin
            faults = faults + 1;
            if (faults <= 10)
              $display({"status mismatch: exp phases=%b pos=%0d busy=%b done=%b ign=%b,",
                        " got phases=%b pos=%0d busy=%b done=%b ign=%b pad=%b"},
                       want.phases, want.position, want.busy_res, want.done_res,
                       want.ignored, got.phases, got.position, got.busy_res,
                       got.done_res, got.ignored, out_tdata[15:14]);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TRAVEL_STEPS: cfg_total  = cfg_data;
          CFG_STEP_PERIOD:  cfg_period = cfg_data;
          CFG_HALF_STEP:    cfg_half   = cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        step_motor_model(in_tuser, in_tdata, next_status);
        pending_status.push_back(next_status);
      end
      fault_count    <= faults;
      status_backlog <= pending_status.size();
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import stp_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int         QUIET_LIMIT = 4000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] target
  logic [1:0]  in_tuser;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [3:0] phases, [10:4] position, [11] busy_res,
                           // [12] done_res, [13] ignored, [15:14] zero
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int fault_count;
  int status_backlog;
  int quiet_cycles;
  int rx_stall;
  bit tx_calm;
  bit rx_calm;

  stepper_position_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  stepper_status_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fault_count    (fault_count),
    .status_backlog (status_backlog)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // stalls on the status side, one draw per word
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      rx_stall = rx_calm ? 0 : $urandom_range(0, 9);
      if (rx_stall != 0) begin
        out_tready <= 1'b0;
        repeat (rx_stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_cmd(input logic [1:0] op, input logic [7:0] tgt);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= tgt;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // hold off commands until every status word is back
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (status_backlog != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic reprogram(input logic [15:0] total, input logic [15:0] period,
                           input logic half);
    settle();
    write_reg(CFG_TRAVEL_STEPS, total);
    write_reg(CFG_STEP_PERIOD, period);
    write_reg(CFG_HALF_STEP, {15'd0, half});
    cfg_valid <= 1'b0;
  endtask

  // mostly in range, now and then the full byte to exercise clamping
  function automatic logic [7:0] pick_target();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 100));
  endfunction

  task automatic run_phase(input logic [15:0] total, input logic [15:0] period,
                           input logic half, input int count);
    int  sent;
    int  burst;
    int  roll;
    bit  drained;
    sent    = 0;
    drained = 0;
    reprogram(total, period, half);
    tx_calm = ($urandom_range(0, 2) == 0);
    rx_calm = ($urandom_range(0, 2) == 0);
    while (sent < count) begin
      if (!drained && sent >= count / 2) begin
        settle();
        drained = 1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        // a move followed by a run of ticks, with the odd stray command
        send_cmd(OP_SET, pick_target());
        burst = $urandom_range(1, 40);
        repeat (burst) begin
          roll = $urandom_range(0, 49);
          if (roll == 0)      send_cmd(OP_STOP, 8'($urandom));
          else if (roll == 1) send_cmd(OP_SPARE, 8'($urandom));
          else if (roll == 2) send_cmd(OP_SET, pick_target());
          else                send_cmd(OP_TICK, 8'($urandom));
        end
        sent = sent + burst + 1;
      end else begin
        if (roll < 85)      send_cmd(OP_STOP, 8'($urandom));
        else if (roll < 92) send_cmd(OP_SPARE, 8'($urandom));
        else                send_cmd(OP_SET, pick_target());
        sent = sent + 1;
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_TICK;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_TRAVEL_STEPS;
    cfg_data  <= '0;
    tx_calm   = 0;
    rx_calm   = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults after reset
    send_cmd(OP_TICK, 8'hFF);
    send_cmd(OP_STOP, 8'h00);
    send_cmd(OP_SPARE, 8'hAA);
    send_cmd(OP_SET, 8'd0);
    send_cmd(OP_SET, 8'd255);
    send_cmd(OP_SET, 8'd50);
    repeat (3) send_cmd(OP_TICK, 8'h55);
    send_cmd(OP_STOP, 8'hFF);

    // one-beat moves both ways
    reprogram(16'd1, 16'd1, 1'b1);
    send_cmd(OP_SET, 8'd100);
    send_cmd(OP_TICK, 8'h00);
    send_cmd(OP_TICK, 8'h00);
    send_cmd(OP_SET, 8'd0);
    send_cmd(OP_TICK, 8'h00);

    // zero travel steps and zero period in full-step mode
    reprogram(16'd0, 16'd0, 1'b0);
    send_cmd(OP_SET, 8'd37);
    send_cmd(OP_TICK, 8'h00);
    send_cmd(OP_TICK, 8'h00);

    // switch to half-step partway through a reverse move
    reprogram(16'd200, 16'd1, 1'b0);
    send_cmd(OP_SET, 8'd100);
    repeat (4) send_cmd(OP_TICK, 8'h00);
    reprogram(16'd200, 16'd1, 1'b1);
    repeat (4) send_cmd(OP_TICK, 8'h00);
    send_cmd(OP_STOP, 8'h00);

    run_phase(16'd100, 16'd1, 1'b1, 200);
    run_phase(16'd100, 16'd2, 1'b0, 200);
    run_phase(16'd1, 16'd1, 1'b0, 200);
    run_phase(16'd0, 16'd0, 1'b1, 200);
    run_phase(16'd65535, 16'd1, 1'b1, 200);
    run_phase(16'd200, 16'd65535, 1'b1, 150);
    run_phase(16'd37, 16'd3, 1'b0, 200);
    run_phase(16'd1000, 16'd1, 1'b1, 200);
    run_phase(16'd65535, 16'd65535, 1'b0, 100);
    run_phase(16'd4096, 16'd1000, 1'b1, 150);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (status_backlog != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/stp_pkg.sv
hdl/stp_cfg.sv
hdl/stp_core.sv
hdl/stepper_position_sequencer.sv
test/stepper_status_checker.sv
test/tb_top.sv
